/* hw/rtl/qamcm_pkg.sv */
// Shared types, constants and level tables for the QAM constellation mapper.
package qamcm_pkg;

  localparam int unsigned SYMBOLS   = 8;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned LEVELS_W  = SYMBOLS * LEVEL_W;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned USED_W    = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_BPSK  = 3'd0,
    MODE_QPSK  = 3'd1,
    MODE_QAM16 = 3'd2,
    MODE_QAM64 = 3'd3,
    MODE_QAM256 = 3'd4
  } mode_t;

  typedef logic signed [LEVEL_W-1:0] level_t;

  // Bit fields that one symbol may draw on, one per modulation.
  typedef struct packed {
    logic       bpsk;
    logic [1:0] qpsk;
    logic [3:0] qam16;
    logic [5:0] qam64;
    logic [7:0] qam256;
  } lane_bits_t;

  typedef struct packed {
    level_t i;
    level_t q;
  } level_pair_t;

  function automatic level_t lv_pm1(input logic b);
    lv_pm1 = b ? 5'sd1 : -5'sd1;
  endfunction

  function automatic level_t lv16(input logic [1:0] c);
    case (c)
      2'b00:   lv16 = -5'sd3;
      2'b01:   lv16 = -5'sd1;
      2'b10:   lv16 = 5'sd3;
      2'b11:   lv16 = 5'sd1;
      default: lv16 = '0;
    endcase
  endfunction

  function automatic level_t lv64(input logic [2:0] c);
    case (c)
      3'b000:  lv64 = -5'sd7;
      3'b001:  lv64 = -5'sd5;
      3'b010:  lv64 = -5'sd1;
      3'b011:  lv64 = -5'sd3;
      3'b100:  lv64 = 5'sd7;
      3'b101:  lv64 = 5'sd5;
      3'b110:  lv64 = 5'sd1;
      3'b111:  lv64 = 5'sd3;
      default: lv64 = '0;
    endcase
  endfunction

  function automatic level_t lv256(input logic [3:0] c);
    case (c)
      4'h0:    lv256 = -5'sd1;
      4'h1:    lv256 = -5'sd15;
      4'h2:    lv256 = -5'sd7;
      4'h3:    lv256 = -5'sd9;
      4'h4:    lv256 = -5'sd3;
      4'h5:    lv256 = -5'sd13;
      4'h6:    lv256 = -5'sd5;
      4'h7:    lv256 = -5'sd11;
      4'h8:    lv256 = 5'sd1;
      4'h9:    lv256 = 5'sd15;
      4'hA:    lv256 = 5'sd7;
      4'hB:    lv256 = 5'sd9;
      4'hC:    lv256 = 5'sd3;
      4'hD:    lv256 = 5'sd13;
      4'hE:    lv256 = 5'sd5;
      4'hF:    lv256 = 5'sd11;
      default: lv256 = '0;
    endcase
  endfunction

  function automatic logic [USED_W-1:0] bytes_for_mode(input logic [MODE_W-1:0] m);
    case (m)
      MODE_BPSK:   bytes_for_mode = 4'd1;
      MODE_QPSK:   bytes_for_mode = 4'd2;
      MODE_QAM16:  bytes_for_mode = 4'd4;
      MODE_QAM64:  bytes_for_mode = 4'd6;
      MODE_QAM256: bytes_for_mode = 4'd8;
      default:     bytes_for_mode = '0;
    endcase
  endfunction

endpackage

/* hw/rtl/qamcm_if.sv */
// Valid/ready channel interfaces for the mapper's input words and result points.
interface qamcm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_bytes;

  modport source (output valid, output data_bytes, input ready);
  modport sink   (input valid, input data_bytes, output ready);
endinterface

interface qamcm_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] inphase_levels;
  logic [39:0] quadrature_levels;
  logic [3:0]  bytes_used;

  modport source (output valid, output inphase_levels, output quadrature_levels,
                  output bytes_used, input ready);
  modport sink   (input valid, input inphase_levels, input quadrature_levels,
                  input bytes_used, output ready);
endinterface

/* hw/rtl/qam_constellation_mapper_core.sv */
// Top level of the Gray-coded QAM constellation mapper.
//
//   channel | direction | payload                                       | transfer
//   in_if   | in        | data_bytes[63:0]                              | valid & ready
//   out_if  | out       | inphase_levels, quadrature_levels, bytes_used | valid & ready
//   cfg     | in        | cfg_wr_data[2:0] (mode)                       | cfg_wr_en
//
// One word per clock unless stalled: eight lanes map all symbols in parallel, and
// the merge register presents the result in the cycle after the input transfer.
// The input is ready whenever the output register is empty or being taken.
// A stalled output holds its word; reset (rst_n low, synchronous) empties the
// output register and sets the mode to BPSK.
module qam_constellation_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  qamcm_in_if.sink    in_if,
  qamcm_out_if.source out_if,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data
);
  import qamcm_pkg::*;

  logic [MODE_W-1:0] mode_r;
  lane_bits_t        bits  [SYMBOLS];
  level_pair_t       lanes [SYMBOLS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BPSK;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // 64-QAM groups are 24 bits wide and hold four symbols, so symbol k sits at 6k
  for (genvar k = 0; k < SYMBOLS; k++) begin : g_lane
    assign bits[k].bpsk   = in_if.data_bytes[k];
    assign bits[k].qpsk   = in_if.data_bytes[2*k +: 2];
    assign bits[k].qam16  = in_if.data_bytes[4*k +: 4];
    assign bits[k].qam64  = in_if.data_bytes[6*k +: 6];
    assign bits[k].qam256 = in_if.data_bytes[8*k +: 8];

    qamcm_lane u_lane (
      .mode (mode_r),
      .bits (bits[k]),
      .lvl  (lanes[k])
    );
  end

  qamcm_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .lanes     (lanes),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_i     (out_if.inphase_levels),
    .out_q     (out_if.quadrature_levels),
    .out_used  (out_if.bytes_used)
  );

endmodule

/* hw/rtl/qamcm_lane.sv */
// One symbol lane: turns the candidate bit fields into an I/Q level pair.
module qamcm_lane (
  input  logic [2:0]           mode,
  input  qamcm_pkg::lane_bits_t bits,
  output qamcm_pkg::level_pair_t lvl
);
  import qamcm_pkg::*;

  always_comb begin
    lvl = '0;
    case (mode)
      MODE_BPSK: begin
        lvl.i = lv_pm1(bits.bpsk);
        lvl.q = '0;
      end
      MODE_QPSK: begin
        lvl.i = lv_pm1(bits.qpsk[0]);
        lvl.q = lv_pm1(bits.qpsk[1]);
      end
      MODE_QAM16: begin
        lvl.i = lv16(bits.qam16[1:0]);
        lvl.q = lv16(bits.qam16[3:2]);
      end
      MODE_QAM64: begin
        lvl.i = lv64(bits.qam64[2:0]);
        lvl.q = lv64(bits.qam64[5:3]);
      end
      MODE_QAM256: begin
        lvl.i = lv256(bits.qam256[3:0]);
        lvl.q = lv256(bits.qam256[7:4]);
      end
      default: begin
        // undefined mode: report all-zero levels
        lvl = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/qamcm_merge.sv */
// Merge stage: packs the lane results into the registered output word.
module qamcm_merge (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             mode,
  input  qamcm_pkg::level_pair_t lanes [qamcm_pkg::SYMBOLS],
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [39:0]            out_i,
  output logic [39:0]            out_q,
  output logic [3:0]             out_used
);
  import qamcm_pkg::*;

  logic                valid_r;
  logic [LEVELS_W-1:0] i_r, i_nxt;
  logic [LEVELS_W-1:0] q_r, q_nxt;
  logic [USED_W-1:0]   used_r;
  logic                load;

  // take a new word whenever the output slot is empty or drains this cycle
  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    for (int k = 0; k < SYMBOLS; k++) begin
      i_nxt[k*LEVEL_W +: LEVEL_W] = lanes[k].i;
      q_nxt[k*LEVEL_W +: LEVEL_W] = lanes[k].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      i_r    <= i_nxt;
      q_r    <= q_nxt;
      used_r <= bytes_for_mode(mode);
    end
  end

  assign out_valid = valid_r;
  assign out_i     = i_r;
  assign out_q     = q_r;
  assign out_used  = used_r;

endmodule

/* hw/rtl/qamcm_checker.sv */
// Port-level checker for the QAM constellation mapper, bound to the top level.
module qamcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [39:0] out_i,
  input logic [39:0] out_q,
  input logic [3:0]  out_used
);

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_i) && $stable(out_q)
      && $stable(out_used))
    else $error("stalled result changed");

  a_accept_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output is empty");

  a_used_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_used == 4'd0 && out_i == '0 && out_q == '0) ||
      out_used == 4'd1 || out_used == 4'd2 || out_used == 4'd4 ||
      out_used == 4'd6 || out_used == 4'd8)
    else $error("bad bytes_used or nonzero levels on error code");

endmodule

bind qam_constellation_mapper_core qamcm_checker u_qamcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_i     (out_if.inphase_levels),
  .out_q     (out_if.quadrature_levels),
  .out_used  (out_if.bytes_used)
);
